/* sv/assert_macros.svh */
// Assertion macros shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while in reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* sv/rpn_pkg.sv */
// Types and constants of the RPN stack evaluator.
package rpn_pkg;

    localparam int Q_W       = 32;
    localparam int FUNC_W    = 3;
    localparam int STATUS_W  = 3;
    localparam int DEPTH_W   = 4;
    localparam int PROD_W    = 2 * Q_W;
    localparam int FRAC_W    = 16;
    localparam int DVD_W     = Q_W + FRAC_W;
    localparam int DIV_STEPS = DVD_W;
    localparam int DIV_CNT_W = 6;

    localparam logic [Q_W-1:0] Q_MAX = 32'h7FFF_FFFF;
    localparam logic [Q_W-1:0] Q_MIN = 32'h8000_0000;

    typedef enum logic [FUNC_W-1:0] {
        FN_PUSH = 3'd0,
        FN_ADD  = 3'd1,
        FN_SUB  = 3'd2,
        FN_MUL  = 3'd3,
        FN_DIV  = 3'd4
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 3'd0,
        ST_FULL = 3'd1,
        ST_FEW  = 3'd2,
        ST_DIV0 = 3'd3,
        ST_SAT  = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_LOAD,
        S_CALC,
        S_FINISH
    } state_t;

    typedef enum logic [1:0] {
        A_IDLE,
        A_MUL,
        A_DIV,
        A_FIN
    } alu_state_t;

    typedef struct packed {
        logic  start;
        func_t op;
    } alu_req_t;

    typedef struct packed {
        logic    done;
        status_t status;
    } alu_rsp_t;

endpackage

/* sv/rpn_in_if.sv */
// Input channel: one command word (function code and operand).
interface rpn_in_if import rpn_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic [FUNC_W-1:0]       func;
    logic signed [Q_W-1:0]   operand_value;

    modport source (output valid, output func, output operand_value, input ready);
    modport sink   (input valid, input func, input operand_value, output ready);
endinterface

/* sv/rpn_out_if.sv */
// Output channel: one result word (status, top of stack, depth).
interface rpn_out_if import rpn_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic [STATUS_W-1:0]     status;
    logic signed [Q_W-1:0]   top_value;
    logic [DEPTH_W-1:0]      stack_depth;

    modport source (output valid, output status, output top_value, output stack_depth,
                    input ready);
    modport sink   (input valid, input status, input top_value, input stack_depth,
                    output ready);
endinterface

/* sv/rpn_stack_evaluator.sv */
// Top level of the RPN stack evaluator: sequencer, operand stack and result register.
//
// Usage:
//   cmd carries one command word: func (0 push, 1 add, 2 subtract, 3 multiply,
//   4 divide, 5..7 ignored) and operand_value (Q16.16, used by push only).
//   res carries one result word per command: status, top_value (0 when the
//   stack is empty) and stack_depth (entry count modulo 16).
//   The block works on one command at a time; cmd.ready is high only while
//   the sequencer is idle.
// Path from command accept to result valid:
//   push, refused or ignored command: decode, then finish; add, subtract and
//   divide by zero: decode, load, calc, finish; multiply: the same, plus the
//   multiply state of the arithmetic unit; divide: the same, plus the 48-step
//   bit-serial divider in the shared arithmetic unit (one quotient bit per cycle).
//   cmd.ready rises in the cycle res.valid rises, so the next command is taken
//   in the cycle after the result is registered at the earliest.
// The result sits in an output register; a new command is accepted while it
//   waits, but that command's result is held until res is taken.
// Reset empties the stack at once (the entry count clears); stack memory
//   contents are not cleared and are never read before being written.
module rpn_stack_evaluator import rpn_pkg::*; #(
    parameter int STACK_DEPTH = 8
) (
    input  logic      clk,
    input  logic      rst_n,
    rpn_in_if.sink    cmd,
    rpn_out_if.source res
);

    `include "assert_macros.svh"

    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W = $clog2(STACK_DEPTH);

    state_t                state_reg, state_next;
    func_t                 func_reg, func_next;
    logic [Q_W-1:0]        opnd_reg, opnd_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [Q_W-1:0]        top_reg, top_next;
    status_t               status_reg, status_next;
    logic                  out_valid_reg, out_valid_next;
    status_t               out_status_reg, out_status_next;
    logic [Q_W-1:0]        out_top_reg, out_top_next;
    logic [DEPTH_W-1:0]    out_depth_reg, out_depth_next;
    logic [Q_W-1:0]        rd_data_reg;

    logic [Q_W-1:0]        mem [STACK_DEPTH];

    logic                  wr_en;
    logic [IDX_W-1:0]      wr_addr;
    logic [Q_W-1:0]        wr_data;
    logic                  rd_en;
    logic [CNT_W-1:0]      cnt_m2;
    logic                  stack_full;
    logic                  too_few;
    logic                  push_taken;
    logic [CNT_W+DEPTH_W-1:0] cnt_ext;

    alu_req_t              alu_req;
    alu_rsp_t              alu_rsp;
    logic signed [Q_W-1:0] alu_result;

    assign cnt_m2     = count_reg - CNT_W'(2);
    assign stack_full = count_reg >= CNT_W'(STACK_DEPTH);
    assign too_few    = count_reg < CNT_W'(2);
    assign cnt_ext    = (CNT_W+DEPTH_W)'(count_reg);
    assign push_taken = (state_reg == S_DECODE) && (func_reg == FN_PUSH) && !stack_full;

    rpn_alu u_alu (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (alu_req),
        .lhs    (rd_data_reg),
        .rhs    (top_reg),
        .rsp    (alu_rsp),
        .result (alu_result)
    );

    always_comb
    begin
        state_next      = state_reg;
        func_next       = func_reg;
        opnd_next       = opnd_reg;
        count_next      = count_reg;
        top_next        = top_reg;
        status_next     = status_reg;
        out_valid_next  = out_valid_reg & ~res.ready;
        out_status_next = out_status_reg;
        out_top_next    = out_top_reg;
        out_depth_next  = out_depth_reg;
        wr_en           = 1'b0;
        wr_addr         = count_reg[IDX_W-1:0];
        wr_data         = opnd_reg;
        rd_en           = 1'b0;
        alu_req.start   = 1'b0;
        alu_req.op      = func_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    func_next  = func_t'(cmd.func);
                    opnd_next  = cmd.operand_value;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_FINISH;
                case (func_reg)
                    FN_PUSH:
                    begin
                        if (stack_full)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            wr_en       = 1'b1;
                            top_next    = opnd_reg;
                            count_next  = count_reg + CNT_W'(1);
                            status_next = ST_OK;
                        end
                    end
                    FN_ADD, FN_SUB, FN_MUL, FN_DIV:
                    begin
                        if (too_few)
                        begin
                            status_next = ST_FEW;
                        end
                        else
                        begin
                            // fetch the left operand; the right one is the cached top
                            rd_en      = 1'b1;
                            state_next = S_LOAD;
                        end
                    end
                    default:
                    begin
                        status_next = ST_OK;
                    end
                endcase
            end
            S_LOAD:
            begin
                alu_req.start = 1'b1;
                state_next    = S_CALC;
            end
            S_CALC:
            begin
                if (alu_rsp.done)
                begin
                    // drop both operands, push the result in the left one's slot
                    wr_en       = 1'b1;
                    wr_addr     = cnt_m2[IDX_W-1:0];
                    wr_data     = alu_result;
                    top_next    = alu_result;
                    count_next  = count_reg - CNT_W'(1);
                    status_next = alu_rsp.status;
                    state_next  = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (!out_valid_reg || res.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    out_top_next    = (count_reg == '0) ? '0 : top_reg;
                    out_depth_next  = cnt_ext[DEPTH_W-1:0];
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg       <= func_next;
        opnd_reg       <= opnd_next;
        top_reg        <= top_next;
        status_reg     <= status_next;
        out_status_reg <= out_status_next;
        out_top_reg    <= out_top_next;
        out_depth_reg  <= out_depth_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[cnt_m2[IDX_W-1:0]];
        end
    end

    assign cmd.ready       = (state_reg == S_IDLE);
    assign res.valid       = out_valid_reg;
    assign res.status      = out_status_reg;
    assign res.top_value   = out_top_reg;
    assign res.stack_depth = out_depth_reg;

    `ASSERT_IMPL(a_depth_bound, clk, rst_n, 1'b1, count_reg <= CNT_W'(STACK_DEPTH))
    `ASSERT_IMPL(a_alu_done_in_calc, clk, rst_n, alu_rsp.done, state_reg == S_CALC)
    `ASSERT_NEXT(a_push_grows, clk, rst_n, push_taken, count_reg == $past(count_reg) + CNT_W'(1))

endmodule

/* sv/rpn_alu.sv */
// Shared Q16.16 arithmetic unit: add, subtract, multiply, bit-serial divide.
module rpn_alu import rpn_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  alu_req_t              req,
    input  logic signed [Q_W-1:0] lhs,
    input  logic signed [Q_W-1:0] rhs,
    output alu_rsp_t              rsp,
    output logic signed [Q_W-1:0] result
);

    `include "assert_macros.svh"

    alu_state_t              state_reg, state_next;
    logic                    done_reg, done_next;
    status_t                 status_reg, status_next;
    logic [Q_W-1:0]          result_reg, result_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic [DVD_W-1:0]        dvd_reg, dvd_next;
    logic [Q_W-1:0]          rem_reg, rem_next;
    logic [Q_W-1:0]          mb_reg, mb_next;
    logic                    neg_reg, neg_next;
    logic [DIV_CNT_W-1:0]    cnt_reg, cnt_next;

    logic [Q_W:0]            sum;
    logic [Q_W:0]            dif;
    logic signed [PROD_W-1:0] prod_w;
    logic [Q_W-1:0]          lhs_mag;
    logic [Q_W-1:0]          rhs_mag;
    logic [Q_W:0]            shifted;
    logic [Q_W+1:0]          trial;
    logic                    fits;
    logic                    mul_ok;
    logic                    pos_ovf;
    logic                    neg_ovf;

    assign sum     = {lhs[Q_W-1], lhs} + {rhs[Q_W-1], rhs};
    assign dif     = {lhs[Q_W-1], lhs} - {rhs[Q_W-1], rhs};
    assign prod_w  = lhs * rhs;
    assign lhs_mag = lhs[Q_W-1] ? (~lhs + Q_W'(1)) : lhs;
    assign rhs_mag = rhs[Q_W-1] ? (~rhs + Q_W'(1)) : rhs;

    // One restoring step: shift in the next dividend bit, try the subtract.
    assign shifted = {rem_reg, dvd_reg[DVD_W-1]};
    assign trial   = {1'b0, shifted} - {2'b00, mb_reg};
    assign fits    = ~trial[Q_W+1];

    // Product bits above the kept word must all match its sign bit.
    assign mul_ok  = (&prod_reg[PROD_W-1:Q_W+FRAC_W-1]) | ~(|prod_reg[PROD_W-1:Q_W+FRAC_W-1]);
    assign pos_ovf = dvd_reg > {{(DVD_W-Q_W){1'b0}}, Q_MAX};
    assign neg_ovf = dvd_reg > {{(DVD_W-Q_W){1'b0}}, Q_MIN};

    always_comb
    begin
        state_next  = state_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        result_next = result_reg;
        prod_next   = prod_reg;
        dvd_next    = dvd_reg;
        rem_next    = rem_reg;
        mb_next     = mb_reg;
        neg_next    = neg_reg;
        cnt_next    = cnt_reg;

        case (state_reg)
            A_IDLE:
            begin
                if (req.start)
                begin
                    case (req.op)
                        FN_ADD:
                        begin
                            done_next = 1'b1;
                            if (sum[Q_W] != sum[Q_W-1])
                            begin
                                status_next = ST_SAT;
                                result_next = sum[Q_W] ? Q_MIN : Q_MAX;
                            end
                            else
                            begin
                                status_next = ST_OK;
                                result_next = sum[Q_W-1:0];
                            end
                        end
                        FN_SUB:
                        begin
                            done_next = 1'b1;
                            if (dif[Q_W] != dif[Q_W-1])
                            begin
                                status_next = ST_SAT;
                                result_next = dif[Q_W] ? Q_MIN : Q_MAX;
                            end
                            else
                            begin
                                status_next = ST_OK;
                                result_next = dif[Q_W-1:0];
                            end
                        end
                        FN_MUL:
                        begin
                            prod_next  = prod_w;
                            state_next = A_MUL;
                        end
                        FN_DIV:
                        begin
                            if (rhs == '0)
                            begin
                                done_next   = 1'b1;
                                status_next = ST_DIV0;
                                result_next = lhs[Q_W-1] ? Q_MIN : Q_MAX;
                            end
                            else
                            begin
                                neg_next   = lhs[Q_W-1] ^ rhs[Q_W-1];
                                mb_next    = rhs_mag;
                                dvd_next   = {lhs_mag, {FRAC_W{1'b0}}};
                                rem_next   = '0;
                                cnt_next   = '0;
                                state_next = A_DIV;
                            end
                        end
                        default:
                        begin
                            done_next   = 1'b1;
                            status_next = ST_OK;
                        end
                    endcase
                end
            end
            A_MUL:
            begin
                done_next  = 1'b1;
                state_next = A_IDLE;
                if (mul_ok)
                begin
                    status_next = ST_OK;
                    result_next = prod_reg[Q_W+FRAC_W-1:FRAC_W];
                end
                else
                begin
                    status_next = ST_SAT;
                    result_next = prod_reg[PROD_W-1] ? Q_MIN : Q_MAX;
                end
            end
            A_DIV:
            begin
                rem_next = fits ? trial[Q_W-1:0] : shifted[Q_W-1:0];
                dvd_next = {dvd_reg[DVD_W-2:0], fits};
                cnt_next = cnt_reg + DIV_CNT_W'(1);
                if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = A_FIN;
                end
            end
            A_FIN:
            begin
                done_next  = 1'b1;
                state_next = A_IDLE;
                if (neg_reg)
                begin
                    status_next = neg_ovf ? ST_SAT : ST_OK;
                    result_next = neg_ovf ? Q_MIN : (~dvd_reg[Q_W-1:0] + Q_W'(1));
                end
                else
                begin
                    status_next = pos_ovf ? ST_SAT : ST_OK;
                    result_next = pos_ovf ? Q_MAX : dvd_reg[Q_W-1:0];
                end
            end
            default:
            begin
                state_next = A_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= A_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        result_reg <= result_next;
        prod_reg   <= prod_next;
        dvd_reg    <= dvd_next;
        rem_reg    <= rem_next;
        mb_reg     <= mb_next;
        neg_reg    <= neg_next;
        cnt_reg    <= cnt_next;
    end

    assign rsp.done   = done_reg;
    assign rsp.status = status_reg;
    assign result     = result_reg;

    `ASSERT_IMPL(a_rem_below_divisor, clk, rst_n, state_reg == A_DIV, rem_reg < mb_reg)
    `ASSERT_NEXT(a_done_single, clk, rst_n, done_reg, !done_reg)
    `ASSERT_IMPL(a_start_when_idle, clk, rst_n, req.start, state_reg == A_IDLE)

endmodule
